// ===== src/acmc_pkg.sv =====
// shared types, constants and wrap helpers for the alarm clock menu controller
package acmc_pkg;

    localparam int unsigned HOURS_PER_DAY    = 24;
    localparam int unsigned MINUTES_PER_HOUR = 60;
    localparam int unsigned NOTICE_SECONDS   = 4;
    localparam int unsigned RING_SECONDS     = 5;

    localparam logic [4:0] MAX_HOUR   = 5'(HOURS_PER_DAY - 1);
    localparam logic [5:0] MAX_MINUTE = 6'(MINUTES_PER_HOUR - 1);

    typedef enum logic [2:0] {
        OP_MENU       = 3'd0,
        OP_OK         = 3'd1,
        OP_PLUS       = 3'd2,
        OP_MINUS      = 3'd3,
        OP_TICK       = 3'd4,
        OP_LOAD_TIME  = 3'd5,
        OP_LOAD_ALARM = 3'd6
    } op_t;

    typedef enum logic [3:0] {
        MODE_SHOW     = 4'd0,
        MODE_SET      = 4'd1,
        MODE_SET_HOUR = 4'd2,
        MODE_SET_MIN  = 4'd3,
        MODE_AL       = 4'd4,
        MODE_AL_HOUR  = 4'd5,
        MODE_AL_MIN   = 4'd6,
        MODE_RING     = 4'd7,
        MODE_OFF      = 4'd8
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [4:0]  wake_hour;
        logic [5:0]  wake_minute;
        logic        suppress;
        logic [2:0]  notice;
        logic [2:0]  ring;
    } clk_state_t;

    function automatic logic [4:0] hour_up(input logic [4:0] v);
        logic [5:0] s;
        s = {1'b0, v} + 6'd1;
        return (s >= 6'(HOURS_PER_DAY)) ? 5'd0 : s[4:0];
    endfunction

    function automatic logic [4:0] hour_down(input logic [4:0] v);
        return (v == 5'd0 || v > MAX_HOUR) ? MAX_HOUR : v - 5'd1;
    endfunction

    function automatic logic [5:0] minute_up(input logic [5:0] v);
        logic [6:0] s;
        s = {1'b0, v} + 7'd1;
        return (s >= 7'(MINUTES_PER_HOUR)) ? 6'd0 : s[5:0];
    endfunction

    function automatic logic [5:0] minute_down(input logic [5:0] v);
        return (v == 6'd0 || v > MAX_MINUTE) ? MAX_MINUTE : v - 6'd1;
    endfunction

    function automatic logic [4:0] sat_hour(input logic [4:0] v);
        return (v > MAX_HOUR) ? MAX_HOUR : v;
    endfunction

    function automatic logic [5:0] sat_minute(input logic [5:0] v);
        return (v > MAX_MINUTE) ? MAX_MINUTE : v;
    endfunction

endpackage

// ===== src/acmc_update.sv =====
// next-state logic: applies one event to the clock state
module acmc_update (
    input  acmc_pkg::clk_state_t cur,
    input  logic [2:0]           op,
    input  logic [4:0]           hour,
    input  logic [5:0]           minute,
    input  logic [5:0]           second,
    input  logic                 alarm_enable,
    output acmc_pkg::clk_state_t nxt
);
    import acmc_pkg::*;

    logic adj_up;

    assign adj_up = (op == OP_PLUS);

    always_comb
    begin
        nxt = cur;
        unique case (op_t'(op))
            OP_MENU:
            begin
                if (cur.mode == MODE_SHOW)
                begin
                    nxt.mode = MODE_SET;
                end
                else if (cur.mode == MODE_SET)
                begin
                    nxt.mode = MODE_AL;
                end
            end
            OP_OK:
            begin
                unique case (cur.mode)
                    MODE_SET:      nxt.mode = MODE_SET_HOUR;
                    MODE_SET_HOUR: nxt.mode = MODE_SET_MIN;
                    MODE_SET_MIN:  nxt.mode = MODE_SHOW;
                    MODE_AL:
                    begin
                        if (!alarm_enable)
                        begin
                            nxt.mode   = MODE_OFF;
                            nxt.notice = 3'(NOTICE_SECONDS);
                        end
                        else
                        begin
                            nxt.mode = MODE_AL_HOUR;
                        end
                    end
                    MODE_AL_HOUR:  nxt.mode = MODE_AL_MIN;
                    MODE_AL_MIN:   nxt.mode = MODE_SHOW;
                    MODE_RING:
                    begin
                        nxt.mode     = MODE_SHOW;
                        nxt.suppress = 1'b1;
                        nxt.ring     = 3'd0;
                    end
                    default: ;
                endcase
            end
            OP_PLUS, OP_MINUS:
            begin
                unique case (cur.mode)
                    MODE_SET_HOUR:
                        nxt.hour = adj_up ? hour_up(cur.hour) : hour_down(cur.hour);
                    MODE_SET_MIN:
                        nxt.minute = adj_up ? minute_up(cur.minute) : minute_down(cur.minute);
                    MODE_AL_HOUR:
                        nxt.wake_hour = adj_up ? hour_up(cur.wake_hour)
                                               : hour_down(cur.wake_hour);
                    MODE_AL_MIN:
                        nxt.wake_minute = adj_up ? minute_up(cur.wake_minute)
                                                 : minute_down(cur.wake_minute);
                    default: ;
                endcase
            end
            OP_TICK:
            begin
                if (cur.hour == cur.wake_hour && cur.minute == cur.wake_minute)
                begin
                    if (cur.mode == MODE_SHOW && alarm_enable && !cur.suppress)
                    begin
                        nxt.mode = MODE_RING;
                        nxt.ring = 3'(RING_SECONDS);
                    end
                end
                else
                begin
                    nxt.suppress = 1'b0;
                end
                // countdowns run on the values just updated above
                if (nxt.notice > 3'd1)
                begin
                    nxt.notice = nxt.notice - 3'd1;
                end
                else if (nxt.notice == 3'd1)
                begin
                    nxt.mode   = MODE_SHOW;
                    nxt.notice = 3'd0;
                end
                if (nxt.ring > 3'd1)
                begin
                    nxt.ring = nxt.ring - 3'd1;
                end
                else if (nxt.ring == 3'd1)
                begin
                    nxt.mode     = MODE_SHOW;
                    nxt.ring     = 3'd0;
                    nxt.suppress = 1'b1;
                end
            end
            OP_LOAD_TIME:
            begin
                nxt.hour   = sat_hour(hour);
                nxt.minute = sat_minute(minute);
                nxt.second = sat_minute(second);
            end
            OP_LOAD_ALARM:
            begin
                nxt.wake_hour   = sat_hour(hour);
                nxt.wake_minute = sat_minute(minute);
            end
            default: ;
        endcase
    end

endmodule

// ===== src/alarm_clock_menu_controller_top.sv =====
// top level of the alarm clock menu controller
// Usage: each input transaction carries one event in op (menu, ok, plus, minus,
// second tick, load time, load alarm) with hour/minute/second used by the loads.
// Every input transaction yields exactly one output transaction holding the
// mode, time, alarm time and buzzer state after that event.
// An input transaction is taken into an input register; once the output register
// is free or being drained, the state update is applied and the result lands in
// the output register. One transaction per cycle is sustained while out_stall is
// low, since the state registers update together with the result register.
// When out_stall holds the output register, the input register keeps its item
// and in_stall rises once it is full; no transaction is lost or repeated.
// cfg_we/cfg_wdata write alarm_enable; write it only while the block is idle.
// Reset (rst_n low) clears the state to show mode, all times zero, the alarm
// disabled and both valid flags low.
module alarm_clock_menu_controller_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] op,
    input  logic [4:0] hour,
    input  logic [5:0] minute,
    input  logic [5:0] second,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] mode,
    output logic [4:0] time_hour,
    output logic [5:0] time_minute,
    output logic [5:0] time_second,
    output logic [4:0] wake_hour,
    output logic [5:0] wake_minute,
    output logic       buzzer_on
);
    import acmc_pkg::*;

    logic       alarm_enable_reg;
    logic       in_valid_reg;
    logic [2:0] op_reg;
    logic [4:0] hour_reg;
    logic [5:0] minute_reg;
    logic [5:0] second_reg;
    logic       out_valid_reg;
    clk_state_t state_reg;
    clk_state_t state_next;
    clk_state_t res_reg;
    logic       fire;
    logic       in_take;

    // process the held item when the result register is free or being drained
    assign fire     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !fire;
    assign in_take  = in_valid && !in_stall;

    acmc_update u_update (
        .cur          (state_reg),
        .op           (op_reg),
        .hour         (hour_reg),
        .minute       (minute_reg),
        .second       (second_reg),
        .alarm_enable (alarm_enable_reg),
        .nxt          (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_enable_reg <= 1'b0;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            state_reg        <= '{mode: MODE_SHOW, default: '0};
        end
        else
        begin
            if (cfg_we)
            begin
                alarm_enable_reg <= cfg_wdata;
            end
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg     <= op;
            hour_reg   <= hour;
            minute_reg <= minute;
            second_reg <= second;
        end
        if (fire)
        begin
            res_reg <= state_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign mode        = res_reg.mode;
    assign time_hour   = res_reg.hour;
    assign time_minute = res_reg.minute;
    assign time_second = res_reg.second;
    assign wake_hour   = res_reg.wake_hour;
    assign wake_minute = res_reg.wake_minute;
    assign buzzer_on   = (res_reg.mode == MODE_RING);

    // ring countdown only runs while ringing
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.ring != 3'd0 |-> state_reg.mode == MODE_RING)
    else $error("ring countdown active outside ringing mode");

    // off notice countdown only runs in off mode
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.notice != 3'd0 |-> state_reg.mode == MODE_OFF)
    else $error("notice countdown active outside off mode");

    // stored time and alarm stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.hour <= MAX_HOUR && state_reg.wake_hour <= MAX_HOUR &&
        state_reg.minute <= MAX_MINUTE && state_reg.wake_minute <= MAX_MINUTE &&
        state_reg.second <= MAX_MINUTE)
    else $error("stored time out of range");

    // a processed item always shows up as a result
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg && res_reg == state_reg)
    else $error("processed item did not reach the result register");

endmodule
